// File: rtl/core/pmf_pkg.sv
package pmf_pkg;

	// default sizes, overridable at the top level
	localparam int DEF_QUEUE_DEPTH   = 4;
	localparam int DEF_MESSAGE_BYTES = 64;

	// decoupling queues
	localparam int CMD_DEPTH = 2;
	localparam int OUT_DEPTH = 4;
	localparam int OQ_LW     = $clog2(OUT_DEPTH + 1);

	// item kind codes on the request port
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_TOO_LONG = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_LIMIT    = 3'd4;

	typedef enum logic {
		OP_WRITE,
		OP_READ
	} op_t;

	typedef enum logic [1:0] {
		DROP_NONE,
		DROP_FULL,
		DROP_LONG
	} drop_t;

	typedef enum logic {
		ENG_IDLE,
		ENG_STREAM
	} eng_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
		logic [7:0] read_limit;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] out_byte;
		logic       out_byte_valid;
		logic       out_last;
		logic [6:0] message_length;
		logic [2:0] occupancy;
		logic       is_full;
		logic       is_empty;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
		logic [7:0] read_limit;
	} cmd_t;

	// result queue status seen by the engine
	typedef struct packed {
		logic [OQ_LW-1:0] level;
		logic             full;
	} oq_status_t;

	function automatic logic [2:0] drop_status(drop_t d);
		logic [2:0] s;
		case (d)
			DROP_NONE: s = ST_OK;
			DROP_FULL: s = ST_FULL;
			DROP_LONG: s = ST_TOO_LONG;
			default:   s = ST_OK;
		endcase
		return s;
	endfunction

endpackage

// File: rtl/core/pmf_front.sv
module pmf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  pmf_pkg::in_item_t request,
	output logic              cmd_valid,
	output pmf_pkg::cmd_t     cmd,
	input  logic              cmd_take
);
	import pmf_pkg::*;

	localparam int PTRW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int LVLW = $clog2(CMD_DEPTH + 1);

	cmd_t            buf_q [CMD_DEPTH];
	logic [PTRW-1:0] wr_q;
	logic [PTRW-1:0] rd_q;
	logic [LVLW-1:0] level_q;
	cmd_t            cls;
	logic            do_push;
	logic            do_pop;

	// classify the incoming item
	always_comb begin
		cls.op             = (request.kind == KIND_READ) ? OP_READ : OP_WRITE;
		cls.data_byte      = request.data_byte;
		cls.byte_present   = request.byte_present;
		cls.end_of_message = request.end_of_message;
		cls.read_limit     = request.read_limit;
	end

	assign full      = (level_q == LVLW'(CMD_DEPTH));
	assign cmd_valid = (level_q != '0);
	assign cmd       = buf_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	// command storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= cls;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTRW'(CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTRW'(CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// File: rtl/core/pmf_out_queue.sv
module pmf_out_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_push,
	input  pmf_pkg::out_item_t  res_item,
	output pmf_pkg::oq_status_t oq,
	output logic                empty,
	input  logic                pop,
	output pmf_pkg::out_item_t  result
);
	import pmf_pkg::*;

	localparam int PTRW = (OUT_DEPTH > 1) ? $clog2(OUT_DEPTH) : 1;

	out_item_t        buf_q [OUT_DEPTH];
	logic [PTRW-1:0]  wr_q;
	logic [PTRW-1:0]  rd_q;
	logic [OQ_LW-1:0] level_q;
	logic             do_pop;

	assign empty    = (level_q == '0);
	assign result   = buf_q[rd_q];
	assign oq.level = level_q;
	assign oq.full  = (level_q == OQ_LW'(OUT_DEPTH));
	assign do_pop   = pop && !empty;

	// result storage
	always_ff @(posedge clk) begin
		if (res_push) begin
			buf_q[wr_q] <= res_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (res_push) begin
				wr_q <= (wr_q == PTRW'(OUT_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTRW'(OUT_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({res_push, do_pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// File: rtl/core/pmf_engine.sv
module pmf_engine #(
	parameter int QUEUE_DEPTH   = pmf_pkg::DEF_QUEUE_DEPTH,
	parameter int MESSAGE_BYTES = pmf_pkg::DEF_MESSAGE_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  pmf_pkg::cmd_t       cmd,
	output logic                cmd_take,
	input  pmf_pkg::oq_status_t oq,
	output logic                res_push,
	output pmf_pkg::out_item_t  res_item
);
	import pmf_pkg::*;

	localparam int SW        = $clog2(QUEUE_DEPTH);
	localparam int CW        = $clog2(QUEUE_DEPTH + 1);
	localparam int FW        = $clog2(MESSAGE_BYTES + 1);
	localparam int PW        = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
	localparam int AW        = SW + PW;
	localparam int MEM_DEPTH = 1 << AW;

	// message byte store, addressed by {slot, position}
	logic [7:0]    slot_mem [MEM_DEPTH];

	// queue state
	eng_state_t    state_q, state_d;
	logic [SW-1:0] head_q, head_d;
	logic [SW-1:0] tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic [FW-1:0] fill_q, fill_d;
	drop_t         drop_q, drop_d;
	logic [FW-1:0] len_q [QUEUE_DEPTH];

	// read streaming
	logic [SW-1:0] rd_slot_q, rd_slot_d;
	logic [FW-1:0] rd_pos_q, rd_pos_d;
	logic [FW-1:0] rd_len_q, rd_len_d;
	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;

	// combinational helpers
	drop_t         drop_w;
	logic [FW-1:0] fill_w;
	logic [CW-1:0] count_w;
	logic [FW-1:0] head_len;
	logic          mem_we;
	logic          len_we;
	logic          rd_issue;
	logic          last_issue;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;

	assign head_len  = len_q[head_q];
	assign mem_waddr = {tail_q, fill_q[PW-1:0]};
	assign mem_raddr = {rd_slot_q, rd_pos_q[PW-1:0]};

	// next state and results
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		fill_d     = fill_q;
		drop_d     = drop_q;
		rd_slot_d  = rd_slot_q;
		rd_pos_d   = rd_pos_q;
		rd_len_d   = rd_len_q;
		drop_w     = drop_q;
		fill_w     = fill_q;
		count_w    = count_q;
		cmd_take   = 1'b0;
		mem_we     = 1'b0;
		len_we     = 1'b0;
		rd_issue   = 1'b0;
		last_issue = 1'b0;
		res_push   = 1'b0;
		res_item   = '0;

		case (state_q)
			ENG_IDLE: begin
				if (cmd_valid && !valid_s1 && !oq.full) begin
					cmd_take          = 1'b1;
					res_push          = 1'b1;
					res_item.out_last = 1'b1;
					case (cmd.op)
						OP_WRITE: begin
							// full check on the first item of a message
							if (fill_q == '0 && drop_q == DROP_NONE &&
								count_q == CW'(QUEUE_DEPTH)) begin
								drop_w = DROP_FULL;
							end
							if (cmd.byte_present && drop_w == DROP_NONE) begin
								if (fill_q == FW'(MESSAGE_BYTES)) begin
									drop_w = DROP_LONG;
								end else begin
									mem_we = 1'b1;
									fill_w = fill_q + 1'b1;
								end
							end
							res_item.status         = drop_status(drop_w);
							res_item.message_length = 7'(fill_w);
							if (cmd.end_of_message) begin
								if (drop_w == DROP_NONE) begin
									len_we  = 1'b1;
									tail_d  = (tail_q == SW'(QUEUE_DEPTH - 1)) ?
										'0 : tail_q + 1'b1;
									count_w = count_q + 1'b1;
								end
								fill_d = '0;
								drop_d = DROP_NONE;
							end else begin
								fill_d = fill_w;
								drop_d = drop_w;
							end
						end
						OP_READ: begin
							if (count_q == '0) begin
								res_item.status = ST_EMPTY;
							end else if (9'(head_len) > 9'(cmd.read_limit)) begin
								res_item.status         = ST_LIMIT;
								res_item.message_length = 7'(head_len);
							end else begin
								head_d  = (head_q == SW'(QUEUE_DEPTH - 1)) ?
									'0 : head_q + 1'b1;
								count_w = count_q - 1'b1;
								res_item.status         = ST_OK;
								res_item.message_length = 7'(head_len);
								if (head_len != '0) begin
									// bytes follow from the streaming stage
									res_push  = 1'b0;
									state_d   = ENG_STREAM;
									rd_slot_d = head_q;
									rd_pos_d  = '0;
									rd_len_d  = head_len;
								end
							end
						end
						default: ;
					endcase
					res_item.occupancy = 3'(count_w);
					res_item.is_full   = (count_w == CW'(QUEUE_DEPTH));
					res_item.is_empty  = (count_w == '0);
				end
			end
			ENG_STREAM: begin
				// issue a byte read only when the result queue has a slot for it
				if ((OQ_LW + 1)'(oq.level) + (OQ_LW + 1)'(valid_s1) <
					(OQ_LW + 1)'(OUT_DEPTH)) begin
					rd_issue   = 1'b1;
					last_issue = ((rd_pos_q + 1'b1) == rd_len_q);
					rd_pos_d   = rd_pos_q + 1'b1;
					if (last_issue) begin
						state_d = ENG_IDLE;
					end
				end
			end
			default: state_d = ENG_IDLE;
		endcase

		// byte read from the store in the previous cycle
		if (valid_s1) begin
			res_push                = 1'b1;
			res_item.status         = ST_OK;
			res_item.out_byte       = byte_s1;
			res_item.out_byte_valid = 1'b1;
			res_item.out_last       = last_s1;
			res_item.message_length = 7'(rd_len_q);
			res_item.occupancy      = 3'(count_q);
			res_item.is_full        = (count_q == CW'(QUEUE_DEPTH));
			res_item.is_empty       = (count_q == '0);
		end

		count_d = count_w;
	end

	// byte store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= cmd.data_byte;
		end
		if (rd_issue) begin
			byte_s1 <= slot_mem[mem_raddr];
			last_s1 <= last_issue;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ENG_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			fill_q    <= '0;
			drop_q    <= DROP_NONE;
			rd_slot_q <= '0;
			rd_pos_q  <= '0;
			rd_len_q  <= '0;
			valid_s1  <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			fill_q    <= fill_d;
			drop_q    <= drop_d;
			rd_slot_q <= rd_slot_d;
			rd_pos_q  <= rd_pos_d;
			rd_len_q  <= rd_len_d;
			valid_s1  <= rd_issue;
		end
	end

	// stored lengths
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				len_q[i] <= '0;
			end
		end else if (len_we) begin
			len_q[tail_q] <= fill_w;
		end
	end

	// checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("stored message count above queue depth");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(MESSAGE_BYTES))
		else $error("fill position past slot size");

	a_s1_from_stream: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(state_q) == ENG_STREAM)
		else $error("byte stage valid without a streaming read");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !oq.full)
		else $error("result pushed into a full result queue");

endmodule

// File: rtl/core/packet_message_fifo.sv
// Message FIFO: a ring of QUEUE_DEPTH slots of MESSAGE_BYTES bytes each.
// Request channel (push/full): an item with kind 0 writes one message byte,
// end_of_message commits the message; kind 1 reads the oldest message if
// its length is at most read_limit. An item is taken when push && !full.
// Result channel (empty/pop): the oldest result sits on the result port
// while empty is low and leaves when pop && !empty.
// A write item gives one result; a read gives one result per byte (one
// result for an empty message or an error). Each result carries occupancy.
// A write item passes the command queue; the engine takes it from there
// and pushes its result into the result queue in the same cycle. A read's
// bytes also pass the byte store, which has a registered read.
// Throughput: writes run at one item per cycle while the result queue has
// room; a read streams its bytes through the store's single read port, and
// the engine takes no new item until the last byte is pushed.
// A stalled receiver fills the 4-entry result queue, then the engine stops,
// then the 2-entry command queue fills and full rises.
// Reset clears pointers, counts, stored lengths and both queues at once.
module packet_message_fifo #(
	parameter int QUEUE_DEPTH   = pmf_pkg::DEF_QUEUE_DEPTH,
	parameter int MESSAGE_BYTES = pmf_pkg::DEF_MESSAGE_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pmf_pkg::in_item_t  request,
	output logic               empty,
	input  logic               pop,
	output pmf_pkg::out_item_t result
);
	import pmf_pkg::*;

	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_take;
	oq_status_t oq;
	logic       res_push;
	out_item_t  res_item;

	// accept and classify
	pmf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	// message store and read streaming
	pmf_engine #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.MESSAGE_BYTES (MESSAGE_BYTES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.oq        (oq),
		.res_push  (res_push),
		.res_item  (res_item)
	);

	// results toward the receiver
	pmf_out_queue u_out_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_item (res_item),
		.oq       (oq),
		.empty    (empty),
		.pop      (pop),
		.result   (result)
	);

endmodule

// File: bench/message_fifo_checker.sv
`timescale 1ns / 100ps

// Watches both queue channels of the message FIFO, keeps its own copy of the
// slot ring, predicts the results of every accepted item and compares them
// with what comes out.
module message_fifo_checker #(
	parameter int QUEUE_DEPTH   = pmf_pkg::DEF_QUEUE_DEPTH,
	parameter int MESSAGE_BYTES = pmf_pkg::DEF_MESSAGE_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  pmf_pkg::in_item_t  request,
	input  logic               empty,
	input  logic               pop,
	input  pmf_pkg::out_item_t result,
	output int                 error_count,
	output int                 results_owed
);
	import pmf_pkg::*;

	// shadow of the slot ring
	logic [7:0] msg_store [QUEUE_DEPTH][MESSAGE_BYTES];
	int         slot_len [QUEUE_DEPTH];
	int         head_idx;
	int         tail_idx;
	int         stored;
	int         fill;
	drop_t      drop;

	out_item_t  expected_results [$];

	function automatic logic [2:0] drop_code(drop_t d);
		case (d)
			DROP_FULL: return ST_FULL;
			DROP_LONG: return ST_TOO_LONG;
			default:   return ST_OK;
		endcase
	endfunction

	// result with the queue flags taken from the current count
	function automatic out_item_t make_result(logic [2:0] status, logic [7:0] data,
			logic valid, logic last, int len);
		out_item_t r;
		r.status         = status;
		r.out_byte       = data;
		r.out_byte_valid = valid;
		r.out_last       = last;
		r.message_length = 7'(len);
		r.occupancy      = 3'(stored);
		r.is_full        = (stored == QUEUE_DEPTH);
		r.is_empty       = (stored == 0);
		return r;
	endfunction

	task automatic predict_item(input in_item_t it);
		int len;
		logic [2:0] status;
		if (it.kind == KIND_WRITE) begin
			// full check only on the first item of a message
			if (fill == 0 && drop == DROP_NONE && stored >= QUEUE_DEPTH)
				drop = DROP_FULL;
			if (it.byte_present && drop == DROP_NONE) begin
				if (fill >= MESSAGE_BYTES) begin
					drop = DROP_LONG;
				end else begin
					msg_store[tail_idx][fill] = it.data_byte;
					fill++;
				end
			end
			status = drop_code(drop);
			len = fill;
			// end of message: commit unless dropped, then start fresh
			if (it.end_of_message) begin
				if (drop == DROP_NONE) begin
					slot_len[tail_idx] = fill;
					tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
					stored++;
				end
				fill = 0;
				drop = DROP_NONE;
			end
			expected_results.push_back(make_result(status, 8'h00, 1'b0, 1'b1, len));
		end else if (stored == 0) begin
			expected_results.push_back(make_result(ST_EMPTY, 8'h00, 1'b0, 1'b1, 0));
		end else begin
			len = slot_len[head_idx];
			if (len > int'(it.read_limit)) begin
				// message stays stored
				expected_results.push_back(make_result(ST_LIMIT, 8'h00, 1'b0, 1'b1, len));
			end else begin
				int slot;
				slot = head_idx;
				head_idx = (head_idx + 1) % QUEUE_DEPTH;
				stored--;
				if (len == 0)
					expected_results.push_back(make_result(ST_OK, 8'h00, 1'b0, 1'b1, 0));
				for (int i = 0; i < len; i++)
					expected_results.push_back(make_result(ST_OK, msg_store[slot][i], 1'b1,
						i == len - 1, len));
			end
		end
	endtask

	function automatic bit field_ok(string name, int unsigned want, int unsigned got);
		if (want == got)
			return 1'b1;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		return 1'b0;
	endfunction

	task automatic check_result(input out_item_t got);
		out_item_t want;
		bit ok;
		if (expected_results.size() == 0) begin
			error_count++;
			$display("%0t: result with nothing expected, expected none, actual %h",
				$time, got);
			return;
		end
		want = expected_results.pop_front();
		ok = field_ok("status", want.status, got.status);
		ok = field_ok("out_byte", want.out_byte, got.out_byte) & ok;
		ok = field_ok("out_byte_valid", want.out_byte_valid, got.out_byte_valid) & ok;
		ok = field_ok("out_last", want.out_last, got.out_last) & ok;
		ok = field_ok("message_length", want.message_length, got.message_length) & ok;
		ok = field_ok("occupancy", want.occupancy, got.occupancy) & ok;
		ok = field_ok("is_full", want.is_full, got.is_full) & ok;
		ok = field_ok("is_empty", want.is_empty, got.is_empty) & ok;
		if (!ok)
			error_count++;
	endtask

	// results are checked before new items are predicted: a result leaving
	// at an edge never belongs to an item taken at that same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_idx     = 0;
			tail_idx     = 0;
			stored       = 0;
			fill         = 0;
			drop         = DROP_NONE;
			error_count  = 0;
			results_owed = 0;
			for (int s = 0; s < QUEUE_DEPTH; s++)
				slot_len[s] = 0;
			expected_results.delete();
		end else begin
			if (pop && !empty)
				check_result(result);
			if (push && !full)
				predict_item(request);
			results_owed = expected_results.size();
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

// Drives items into the message FIFO, pops results with random stalls, and
// gives the verdict from the checker's count.
module testbench;
	import pmf_pkg::*;

	localparam int QD          = DEF_QUEUE_DEPTH;
	localparam int MB          = DEF_MESSAGE_BYTES;
	localparam int ITEM_TARGET = 410;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 30;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  request;
	logic      empty;
	logic      pop;
	out_item_t result;
	int        error_count;
	int        results_owed;

	int        items_sent;
	bit        steady;
	int        quiet_cycles;

	packet_message_fifo #(
		.QUEUE_DEPTH  (QD),
		.MESSAGE_BYTES(MB)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.request(request),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	message_fifo_checker #(
		.QUEUE_DEPTH  (QD),
		.MESSAGE_BYTES(MB)
	) checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.request     (request),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.error_count (error_count),
		.results_owed(results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// write item; the unused limit field carries random bits
	function automatic in_item_t write_item(logic [7:0] data, logic present, logic eom);
		in_item_t it;
		it.kind           = KIND_WRITE;
		it.data_byte      = data;
		it.byte_present   = present;
		it.end_of_message = eom;
		it.read_limit     = 8'($urandom);
		return it;
	endfunction

	function automatic in_item_t read_item(logic [7:0] limit);
		in_item_t it;
		it                = in_item_t'($urandom);
		it.kind           = KIND_READ;
		it.read_limit     = limit;
		return it;
	endfunction

	// mostly short messages, some empty, a few at or past the slot size
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return $urandom_range(MB, MB + 3);
		if (r < 10)
			return 0;
		return $urandom_range(1, 12);
	endfunction

	function automatic logic [7:0] pick_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 8'hFF;
		if (r < 80)
			return 8'($urandom);
		return 8'($urandom_range(0, 12));
	endfunction

	// offer one item until taken; starts and ends at a falling edge
	task automatic send(input in_item_t it);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			if (!steady && $urandom_range(0, 99) < 13) begin
				push    = 1'b0;
				request = in_item_t'($urandom);
				@(negedge clk);
			end else begin
				push    = 1'b1;
				request = it;
				@(posedge clk);
				taken = !full;
				@(negedge clk);
			end
		end
		items_sent++;
	endtask

	// one message, with stray absent bytes and reads mixed in
	task automatic send_message(input int len, input bit absent_end);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 8)
				send(write_item(8'($urandom), 1'b0, 1'b0));
			if ($urandom_range(0, 99) < 4)
				send(read_item(pick_limit()));
			send(write_item(8'($urandom), 1'b1, (i == len - 1) && !absent_end));
		end
		if (len == 0 || absent_end)
			send(write_item(8'($urandom), 1'b0, 1'b1));
	endtask

	// result side stalls at random
	always @(negedge clk) begin
		if (!arst_n)
			pop = 1'b0;
		else
			pop = steady || ($urandom_range(0, 99) >= 13);
	end

	// watchdog on cycles where neither channel moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		arst_n       = 1'b0;
		push         = 1'b0;
		request      = '0;
		items_sent   = 0;
		steady       = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty read, zero-length message
		send(read_item(8'h00));
		send(write_item(8'h00, 1'b0, 1'b1));
		send(read_item(8'h00));
		// extreme bytes with an absent byte between, limit just too small
		send(write_item(8'h00, 1'b1, 1'b0));
		send(write_item(8'h5A, 1'b0, 1'b0));
		send(write_item(8'hFF, 1'b1, 1'b1));
		send(read_item(8'h01));
		send(read_item(8'hFF));
		// fill the ring, then a message that starts while full
		repeat (QD) send(write_item(8'h00, 1'b0, 1'b1));
		send(write_item(8'hA5, 1'b1, 1'b0));
		send(read_item(8'h00));
		send(write_item(8'h3C, 1'b0, 1'b0));
		send(write_item(8'hC3, 1'b1, 1'b1));
		send(write_item(8'h00, 1'b0, 1'b1));
		repeat (QD) send(read_item(8'hFF));
		send(read_item(8'hFF));

		// full-size message and one past the slot size
		send_message(MB, 1'b0);
		send_message(MB + 1, 1'b0);
		send(read_item(8'(MB - 1)));
		send(read_item(8'(MB)));
		send(read_item(8'hFF));

		// random traffic with a stall-free stretch in the middle
		while (items_sent < ITEM_TARGET) begin
			steady = (items_sent >= 200 && items_sent < 300);
			pick = $urandom_range(0, 99);
			if (pick < 50)
				send_message(pick_len(), $urandom_range(0, 3) == 0);
			else if (pick < 90)
				send(read_item(pick_limit()));
			else
				send(in_item_t'($urandom));
		end
		steady = 1'b0;
		push   = 1'b0;

		// drain, then give late results a chance to show up
		while (results_owed != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (error_count == 0 && results_owed == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: packet_message_fifo.f
rtl/core/pmf_pkg.sv
rtl/core/pmf_front.sv
rtl/core/pmf_out_queue.sv
rtl/core/pmf_engine.sv
rtl/core/packet_message_fifo.sv
bench/message_fifo_checker.sv
bench/testbench.sv
